// ===== src/b64c_pkg.sv =====
// base64 codec package: types, character constants and alphabet functions
// used by the core and the result stage; no dependencies

package b64c_pkg;

    localparam logic       DIR_ENCODE   = 1'b0;
    localparam logic       DIR_DECODE   = 1'b1;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] INVALID_CHAR = 8'hFF;
    localparam int         MAX_RESULTS  = 4;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [1:0]                  last_idx;
        logic                        data_valid;
        logic                        last;
        logic                        status;
    } bundle_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic logic [7:0] dec_char(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else begin
            v = INVALID_CHAR;
        end
        return v;
    endfunction

endpackage

// ===== src/b64c_core.sv =====
// base64 codec core: input register, group state and the encode/decode logic
// that turns one request into a bundle of up to four results; uses b64c_pkg

module b64c_core
    import b64c_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic [7:0] s_data_in,
    input  logic       s_last_in,
    input  logic       s_valid,
    output logic       s_ready,
    output bundle_t    ld_bundle,
    output logic       ld_valid,
    input  logic       ld_ready
);

    logic        dir_reg;
    logic        in_valid_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [23:0] gb_reg, gb_next;
    logic [1:0]  pos_reg, pos_next;
    logic        stop_reg, stop_next;

    logic [2:0]  res_cnt;
    logic        xfer;
    logic [23:0] gb_enc;
    logic [23:0] gb_dec;
    logic [7:0]  cv;
    logic [7:0]  c0, c1, c2, c3;
    bundle_t     bnd;

    always_comb begin
        gb_enc = gb_reg;
        case (pos_reg)
            2'd0:    gb_enc = gb_reg | {data_reg, 16'h0000};
            2'd1:    gb_enc = gb_reg | {8'h00, data_reg, 8'h00};
            default: gb_enc = gb_reg | {16'h0000, data_reg};
        endcase
        c0 = enc_char(gb_enc[23:18]);
        c1 = enc_char(gb_enc[17:12]);
        c2 = enc_char(gb_enc[11:6]);
        c3 = enc_char(gb_enc[5:0]);
        cv = dec_char(data_reg);
        gb_dec = {gb_reg[17:0], 6'b000000} | {16'h0000, cv};
    end

    always_comb begin
        gb_next         = gb_reg;
        pos_next        = pos_reg;
        stop_next       = stop_reg;
        res_cnt         = 3'd0;
        bnd.data        = '0;
        bnd.data_valid  = 1'b1;
        bnd.last        = last_reg;
        bnd.status      = 1'b0;
        if (dir_reg == DIR_ENCODE) begin
            if (pos_reg == 2'd2) begin
                res_cnt  = 3'd4;
                bnd.data = {c3, c2, c1, c0};
                gb_next  = '0;
                pos_next = 2'd0;
            end else if (last_reg) begin
                res_cnt  = 3'd4;
                bnd.data = {PAD_CHAR, (pos_reg == 2'd1) ? c2 : PAD_CHAR, c1, c0};
            end else begin
                gb_next  = gb_enc;
                pos_next = pos_reg + 2'd1;
            end
        end else begin
            if (!stop_reg) begin
                case (pos_reg)
                    2'd0: begin
                        gb_next = {16'h0000, cv};
                    end
                    2'd1: begin
                        gb_next     = gb_dec;
                        res_cnt     = 3'd1;
                        bnd.data[0] = gb_dec[11:4];
                    end
                    default: begin
                        if (data_reg == PAD_CHAR) begin
                            stop_next = 1'b1;
                        end else begin
                            gb_next     = gb_dec;
                            res_cnt     = 3'd1;
                            bnd.data[0] = (pos_reg == 2'd2) ? gb_dec[9:2] : gb_dec[7:0];
                        end
                    end
                endcase
            end
            pos_next   = pos_reg + 2'd1;
            bnd.status = last_reg && (pos_reg != 2'd3);
        end
        if (last_reg) begin
            if (res_cnt == 3'd0) begin
                res_cnt        = 3'd1;
                bnd.data_valid = 1'b0;
            end
            gb_next   = '0;
            pos_next  = 2'd0;
            stop_next = 1'b0;
        end
        bnd.last_idx = 2'(res_cnt - 3'd1);
    end

    assign ld_bundle = bnd;
    assign ld_valid  = in_valid_reg && (res_cnt != 3'd0);
    assign xfer      = in_valid_reg && ((res_cnt == 3'd0) || ld_ready);
    assign s_ready   = !in_valid_reg || xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg      <= DIR_ENCODE;
            in_valid_reg <= 1'b0;
            gb_reg       <= '0;
            pos_reg      <= 2'd0;
            stop_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (xfer) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                dir_reg  <= cfg_wr_data;
                gb_reg   <= '0;
                pos_reg  <= 2'd0;
                stop_reg <= 1'b0;
            end else if (xfer) begin
                gb_reg   <= gb_next;
                pos_reg  <= pos_next;
                stop_reg <= stop_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_in;
            last_reg <= s_last_in;
        end
    end

endmodule

// ===== src/b64c_emit.sv =====
// base64 codec result stage: holds one bundle and hands its results out
// one per cycle on the m_ channel while m_ready is high; uses b64c_pkg

module b64c_emit
    import b64c_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  bundle_t    ld_bundle,
    input  logic       ld_valid,
    output logic       ld_ready,
    output logic [7:0] m_data_out,
    output logic       m_data_valid,
    output logic       m_last_out,
    output logic       m_status,
    output logic       m_valid,
    input  logic       m_ready
);

    bundle_t    bnd_reg;
    logic       bvalid_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       final_take;
    logic       at_end;

    assign at_end     = (idx_reg == bnd_reg.last_idx);
    assign take       = bvalid_reg && m_ready;
    assign final_take = take && at_end;
    assign ld_ready   = !bvalid_reg || final_take;

    assign m_valid      = bvalid_reg;
    assign m_data_out   = bnd_reg.data[idx_reg];
    assign m_data_valid = bnd_reg.data_valid;
    assign m_last_out   = bnd_reg.last && at_end;
    assign m_status     = bnd_reg.status && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg <= 1'b0;
            idx_reg    <= 2'd0;
        end else if (ld_valid && ld_ready) begin
            bvalid_reg <= 1'b1;
            idx_reg    <= 2'd0;
        end else if (final_take) begin
            bvalid_reg <= 1'b0;
        end else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_valid && ld_ready) begin
            bnd_reg <= ld_bundle;
        end
    end

endmodule

// ===== src/base64_stream_codec.sv =====
// Base64 stream codec (RFC 4648) built from b64c_core and b64c_emit; uses b64c_pkg.
// Direction comes from cfg_wr_data (0 encode, 1 decode), written while idle; a
// write also restarts the current group. A request is taken into an input
// register and turned combinationally into up to four results, held in a
// result register and sent one per cycle while m_ready is high. Requests are
// accepted every cycle as long as the result register drains: decode gives at
// most one result per character, so it runs at one character a cycle; encode
// gives four characters per three bytes, so the single result port sets the
// pace. A final request with nothing to decode gives one end marker
// (m_data_valid low). m_status is set on the final result when a decoded
// message length is not a multiple of four.

module base64_stream_codec
    import b64c_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic [7:0] s_data_in,
    input  logic       s_last_in,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_data_out,
    output logic       m_data_valid,
    output logic       m_last_out,
    output logic       m_status,
    output logic       m_valid,
    input  logic       m_ready
);

    bundle_t ld_bundle;
    logic    ld_valid;
    logic    ld_ready;

    b64c_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data_in   (s_data_in),
        .s_last_in   (s_last_in),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .ld_bundle   (ld_bundle),
        .ld_valid    (ld_valid),
        .ld_ready    (ld_ready)
    );

    b64c_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ld_bundle    (ld_bundle),
        .ld_valid     (ld_valid),
        .ld_ready     (ld_ready),
        .m_data_out   (m_data_out),
        .m_data_valid (m_data_valid),
        .m_last_out   (m_last_out),
        .m_status     (m_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// testbench for base64_stream_codec: directed rows then random messages in both directions
// typed rows check against table entries, others against an in-bench base64 predictor; needs b64c_pkg and the rtl

module tb;
    import b64c_pkg::*;

    localparam logic ST_OK         = 1'b0;
    localparam logic ST_BAD_LENGTH = 1'b1;
    localparam int   RANDOM_ITEMS  = 190;
    localparam int   DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       dvalid;
        logic       last;
        logic       status;
    } codec_out_t;

    typedef struct packed {
        logic        dir;
        logic [7:0]  ch;
        logic        lst;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] outs;
        logic        dv;
        logic        st;
    } stim_row_t;

    localparam stim_row_t DIRECTED [24] = '{
        '{DIR_ENCODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_ENCODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_ENCODE, 8'h00, 1'b1, 1'b1, 3'd4, "AAAA", 1'b1, ST_OK},
        '{DIR_ENCODE, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_ENCODE, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, "////", 1'b1, ST_OK},
        '{DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, "/w==", 1'b1, ST_OK},
        '{DIR_ENCODE, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, "AP8=", 1'b1, ST_OK},
        '{DIR_DECODE, "/", 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_DECODE, "/", 1'b0, 1'b1, 3'd1, 32'hFF00_0000, 1'b1, ST_OK},
        '{DIR_DECODE, "/", 1'b0, 1'b1, 3'd1, 32'hFF00_0000, 1'b1, ST_OK},
        '{DIR_DECODE, "/", 1'b1, 1'b1, 3'd1, 32'hFF00_0000, 1'b1, ST_OK},
        '{DIR_DECODE, INVALID_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, "A", 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, 8'h00, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, "Q", 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, ST_OK},
        '{DIR_DECODE, "A", 1'b1, 1'b1, 3'd1, 32'h0, 1'b0, ST_BAD_LENGTH},
        '{DIR_DECODE, "A", 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_DECODE, "A", 1'b0, 1'b1, 3'd1, 32'h0, 1'b1, ST_OK},
        '{DIR_DECODE, PAD_CHAR, 1'b0, 1'b1, 3'd0, 32'h0, 1'b1, ST_OK},
        '{DIR_DECODE, PAD_CHAR, 1'b1, 1'b1, 3'd1, 32'h0, 1'b0, ST_OK}
    };

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic [7:0] s_data_in;
    logic       s_last_in;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] m_data_out;
    logic       m_data_valid;
    logic       m_last_out;
    logic       m_status;
    logic       m_valid;
    logic       m_ready = 1'b0;

    codec_out_t awaited_outputs[$];
    codec_out_t step_results[$];

    logic        direction_q;
    logic [23:0] grp_bits;
    logic [1:0]  grp_pos;
    logic        dec_halted;

    int fail_count    = 0;
    int requests_taken = 0;
    int burst_left    = 0;
    bit drained_once  = 1'b0;
    int stall_left    = 0;
    int stall_mode    = 0;
    int stall_tick    = 0;

    base64_stream_codec u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_data_in    (s_data_in),
        .s_last_in    (s_last_in),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_data_out   (m_data_out),
        .m_data_valid (m_data_valid),
        .m_last_out   (m_last_out),
        .m_status     (m_status),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        string abc;
        abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        return abc[v];
    endfunction

    function automatic logic [7:0] b64_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (b64_symbol(6'(i)) == c) return 8'(i);
        end
        return INVALID_CHAR;
    endfunction

    task automatic add_symbol(input logic [7:0] c, input logic dv);
        codec_out_t o;
        o = '{data: c, dvalid: dv, last: 1'b0, status: ST_OK};
        step_results.push_back(o);
    endtask

    task automatic clear_group();
        grp_bits   = '0;
        grp_pos    = '0;
        dec_halted = 1'b0;
    endtask

    task automatic predict_codec(input logic [7:0] d, input logic l);
        logic       st;
        logic [1:0] p;
        st = ST_OK;
        step_results.delete();
        if (direction_q == DIR_ENCODE) begin
            grp_bits = grp_bits | (24'(d) << (16 - 8 * grp_pos));
            if (grp_pos == 2'd2) begin
                add_symbol(b64_symbol(grp_bits[23:18]), 1'b1);
                add_symbol(b64_symbol(grp_bits[17:12]), 1'b1);
                add_symbol(b64_symbol(grp_bits[11:6]), 1'b1);
                add_symbol(b64_symbol(grp_bits[5:0]), 1'b1);
                grp_bits = '0;
                grp_pos  = '0;
            end else if (l) begin
                add_symbol(b64_symbol(grp_bits[23:18]), 1'b1);
                add_symbol(b64_symbol(grp_bits[17:12]), 1'b1);
                add_symbol(grp_pos == 2'd1 ? b64_symbol(grp_bits[11:6]) : PAD_CHAR, 1'b1);
                add_symbol(PAD_CHAR, 1'b1);
            end else begin
                grp_pos = grp_pos + 2'd1;
            end
        end else begin
            p = grp_pos;
            if (!dec_halted) begin
                if (p == 2'd0) begin
                    grp_bits = 24'(b64_value(d));
                end else if (p == 2'd1) begin
                    grp_bits = (grp_bits << 6) | 24'(b64_value(d));
                    add_symbol(grp_bits[11:4], 1'b1);
                end else if (d == PAD_CHAR) begin
                    dec_halted = 1'b1;
                end else begin
                    grp_bits = (grp_bits << 6) | 24'(b64_value(d));
                    add_symbol(p == 2'd2 ? grp_bits[9:2] : grp_bits[7:0], 1'b1);
                end
            end
            if (l && p != 2'd3) st = ST_BAD_LENGTH;
            grp_pos = p + 2'd1;
        end
        if (l) begin
            if (step_results.size() == 0) add_symbol(8'h00, 1'b0);
            step_results[step_results.size() - 1].last   = 1'b1;
            step_results[step_results.size() - 1].status = st;
            clear_group();
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (awaited_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_direction(input logic v);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        direction_q = v;
        clear_group();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_request(input logic [7:0] d, input logic l, input bit use_pred);
        int gap;
        if (!drained_once && requests_taken == $size(DIRECTED) + RANDOM_ITEMS / 2) begin
            wait_drained();
            drained_once = 1'b1;
        end
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data_in <= d;
        s_last_in <= l;
        do @(posedge aclk); while (s_ready !== 1'b1);
        requests_taken++;
        predict_codec(d, l);
        if (use_pred) begin
            foreach (step_results[k]) awaited_outputs.push_back(step_results[k]);
        end
    endtask

    // receiver stalls: always ready, mostly ready, one in three, coin flip
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= (stall_tick % 3 == 0);
            default: m_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        codec_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_outputs.size() == 0) begin
                $error("m_data_out: expected nothing, got %h", m_data_out);
                fail_count++;
            end else begin
                want = awaited_outputs.pop_front();
                check_field("m_data_out", want.data, m_data_out);
                check_field("m_data_valid", 8'(want.dvalid), 8'(m_data_valid));
                check_field("m_last_out", 8'(want.last), 8'(m_last_out));
                check_field("m_status", 8'(want.status), 8'(m_status));
            end
        end
    end

    initial begin
        codec_out_t  o;
        logic [7:0]  msg[$];
        logic [23:0] w;
        logic        phase_dir;
        int          len;
        int          rem;
        int          sent;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        s_data_in   = 8'h00;
        s_last_in   = 1'b0;
        direction_q = DIR_ENCODE;
        clear_group();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // encode rows run on the reset direction
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].dir != direction_q) set_direction(DIRECTED[i].dir);
            push_request(DIRECTED[i].ch, DIRECTED[i].lst, !DIRECTED[i].typed);
            if (DIRECTED[i].typed) begin
                for (int k = 0; k < DIRECTED[i].n; k++) begin
                    o.data   = DIRECTED[i].outs[31 - 8 * k -: 8];
                    o.dvalid = DIRECTED[i].dv;
                    o.last   = DIRECTED[i].lst && (k == DIRECTED[i].n - 1);
                    o.status = (k == DIRECTED[i].n - 1) ? DIRECTED[i].st : ST_OK;
                    awaited_outputs.push_back(o);
                end
            end
        end

        sent      = 0;
        phase_dir = DIR_ENCODE;
        while (sent < RANDOM_ITEMS) begin
            set_direction(phase_dir);
            repeat ($urandom_range(3, 8)) begin
                msg.delete();
                if (phase_dir == DIR_ENCODE) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(1, 10);
                    repeat (len) msg.push_back(8'($urandom));
                end else if ($urandom_range(0, 3) != 0) begin
                    // well-formed text with canonical padding
                    len = $urandom_range(1, 7);
                    for (int g = 0; g < len; g += 3) begin
                        rem = len - g;
                        w = {8'($urandom), rem >= 2 ? 8'($urandom) : 8'h00,
                             rem >= 3 ? 8'($urandom) : 8'h00};
                        msg.push_back(b64_symbol(w[23:18]));
                        msg.push_back(b64_symbol(w[17:12]));
                        msg.push_back(rem >= 2 ? b64_symbol(w[11:6]) : PAD_CHAR);
                        msg.push_back(rem >= 3 ? b64_symbol(w[5:0]) : PAD_CHAR);
                    end
                end else begin
                    len = $urandom_range(1, 9);
                    repeat (len) begin
                        case ($urandom_range(0, 3))
                            0: msg.push_back(8'($urandom));
                            1: msg.push_back(PAD_CHAR);
                            default: msg.push_back(b64_symbol(6'($urandom)));
                        endcase
                    end
                end
                foreach (msg[k]) push_request(msg[k], k == msg.size() - 1, 1'b1);
                sent += msg.size();
            end
            phase_dir = ~phase_dir;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/b64c_pkg.sv
src/b64c_core.sv
src/b64c_emit.sv
src/base64_stream_codec.sv
tb/sv/tb.sv
